// ===== design/ppbr_pkg.sv =====
// Package for the ping-pong block retransmit design.
// Holds buffer geometry constants and derived widths; no dependencies.
package ppbr_pkg;

	localparam int BLOCK_WORDS = 32;
	localparam int STORE_WORDS = 2 * BLOCK_WORDS;
	localparam int WORD_W      = 16;
	localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int IDX_W       = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// One buffered result: word plus end-of-burst mark.
	typedef struct packed {
		word_t word;
		logic  last;
	} out_entry_t;

endpackage

// ===== design/ppbr_if.sv =====
// Valid/ready channel interfaces for received and retransmitted words.
// Depends on ppbr_pkg for the word type.
interface ppbr_rx_if;
	logic           valid;
	logic           ready;
	ppbr_pkg::word_t rx_word;

	modport source (output valid, output rx_word, input ready);
	modport sink   (input valid, input rx_word, output ready);
endinterface

interface ppbr_tx_if;
	logic           valid;
	logic           ready;
	ppbr_pkg::word_t tx_word;
	logic           tx_last;

	modport source (output valid, output tx_word, output tx_last, input ready);
	modport sink   (input valid, input tx_word, input tx_last, output ready);
endinterface

// ===== design/ping_pong_block_retransmit.sv =====
// Ping-pong double buffer: stores received words, replays each filled half.
// Depends on ppbr_pkg and the channel interfaces in ppbr_if.sv.
//
//   channel | dir | payload            | request accepted when
//   --------+-----+--------------------+-----------------------
//   rx      | in  | rx_word[15:0]      | rx.valid && rx.ready
//   tx      | out | tx_word[15:0], last| tx.valid && tx.ready
//
// One received word is taken per cycle; it is written to the word memory at once.
// Filling a half starts a burst of BLOCK_WORDS reads, one per cycle through the
// single read port while the queue has room, into a two-entry output queue.
// Reading the next words proceeds while a result waits; tx stalls only stop the reads.
// rx stalls only while the write position sits inside the half still being replayed.
// Reset (arst_n low) clears the write position, burst state and output queue.
module ping_pong_block_retransmit (
	input  logic            clk,
	input  logic            arst_n,
	ppbr_rx_if.sink         rx,
	ppbr_tx_if.source       tx
);

	localparam ppbr_pkg::addr_t BLOCK_BASE = ppbr_pkg::ADDR_W'(ppbr_pkg::BLOCK_WORDS);
	localparam ppbr_pkg::addr_t HALF_END   = ppbr_pkg::ADDR_W'(ppbr_pkg::BLOCK_WORDS - 1);
	localparam ppbr_pkg::addr_t STORE_END  = ppbr_pkg::ADDR_W'(ppbr_pkg::STORE_WORDS - 1);
	localparam ppbr_pkg::idx_t  IDX_LAST   = ppbr_pkg::IDX_W'(ppbr_pkg::BLOCK_WORDS - 1);

	// Word memory
	ppbr_pkg::word_t mem [ppbr_pkg::STORE_WORDS];

	ppbr_pkg::addr_t wr_pos_q;
	logic            drain_active_q;
	logic            drain_half_q;
	logic            pending_q;
	ppbr_pkg::idx_t  rd_idx_q;

	logic            rd_v_s1;
	logic            rd_last_s1;
	ppbr_pkg::word_t rd_data_s1;

	ppbr_pkg::out_entry_t q0_q;
	ppbr_pkg::out_entry_t q1_q;
	logic [1:0]           cnt_q;

	logic            wr_half;
	logic            wr_end;
	logic            in_fire;
	logic            done_evt;
	logic            pop;
	logic            issue;
	logic            fin;
	logic [2:0]      occ;
	ppbr_pkg::addr_t rd_addr;
	ppbr_pkg::out_entry_t push_entry;

	// Write side
	assign wr_half  = (wr_pos_q >= BLOCK_BASE);
	assign wr_end   = (wr_pos_q == HALF_END) || (wr_pos_q == STORE_END);
	assign rx.ready = !(drain_active_q && (wr_half == drain_half_q));
	assign in_fire  = rx.valid && rx.ready;
	assign done_evt = in_fire && wr_end;

	// Read side: issue when the queue can absorb the returning word
	assign pop     = tx.valid && tx.ready;
	assign occ     = {1'b0, cnt_q} + {2'b00, rd_v_s1} - {2'b00, pop};
	assign issue   = drain_active_q && (occ <= 3'd1);
	assign fin     = issue && (rd_idx_q == IDX_LAST);
	assign rd_addr = (drain_half_q ? BLOCK_BASE : '0) + ppbr_pkg::ADDR_W'(rd_idx_q);

	// Store incoming words
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mem[wr_pos_q] <= rx.rx_word;
		end
	end

	// Read the memory
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
			rd_last_s1 <= (rd_idx_q == IDX_LAST);
		end
	end

	// Advance write position and burst control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q       <= '0;
			drain_active_q <= 1'b0;
			drain_half_q   <= 1'b0;
			pending_q      <= 1'b0;
			rd_idx_q       <= '0;
			rd_v_s1        <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (in_fire) begin
				wr_pos_q <= (wr_pos_q == STORE_END) ? '0 : wr_pos_q + 1'b1;
			end
			if (issue && !fin) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			priority if (fin) begin
				rd_idx_q <= '0;
				if (pending_q) begin
					drain_half_q <= !drain_half_q;
					pending_q    <= 1'b0;
				end else if (done_evt) begin
					drain_half_q <= wr_half;
				end else begin
					drain_active_q <= 1'b0;
				end
			end else if (done_evt) begin
				if (drain_active_q) begin
					pending_q <= 1'b1;
				end else begin
					drain_active_q <= 1'b1;
					drain_half_q   <= wr_half;
					rd_idx_q       <= '0;
				end
			end else begin
				pending_q <= pending_q;
			end
		end
	end

	// Output queue: head drives tx
	assign push_entry = '{word: rd_data_s1, last: rd_last_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= 2'(occ);
		end
	end

	always_ff @(posedge clk) begin
		unique case ({rd_v_s1, pop})
			2'b11: begin
				if (cnt_q == 2'd1) begin
					q0_q <= push_entry;
				end else begin
					q0_q <= q1_q;
					q1_q <= push_entry;
				end
			end
			2'b01: begin
				q0_q <= q1_q;
			end
			2'b10: begin
				if (cnt_q == 2'd0) begin
					q0_q <= push_entry;
				end else begin
					q1_q <= push_entry;
				end
			end
			default: begin
				q0_q <= q0_q;
			end
		endcase
	end

	assign tx.valid   = (cnt_q != 2'd0);
	assign tx.tx_word = q0_q.word;
	assign tx.tx_last = q0_q.last;

	// Checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue overflow");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && drain_active_q) |-> (wr_half != drain_half_q))
		else $error("write into half being replayed");

	a_pending_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> drain_active_q)
		else $error("pending burst without active burst");

	a_read_return: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> rd_v_s1)
		else $error("issued read did not return");

endmodule
